>>> rtl/core/sis_pkg.sv
// shared types and constants of the stable descending insertion sorter
package sis_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 16;
    localparam int TAG_BITS  = 16;
    localparam int FILL_BITS = $clog2(CAPACITY + 1);
    localparam int DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int PAD_BITS  = DATA_BITS - KEY_BITS - TAG_BITS;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
    } rec_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

>>> rtl/core/sis_cell.sv
// one cell of the insertion chain: holds a record, compares and shifts
module sis_cell (
    input  logic              clk,
    input  sis_pkg::cell_ctrl_t ctrl,
    input  logic              occupied,
    input  sis_pkg::rec_t     new_rec,
    input  sis_pkg::rec_t     left_rec,
    input  logic              left_gt,
    input  sis_pkg::rec_t     right_rec,
    output sis_pkg::rec_t     rec,
    output logic              gt
);

    sis_pkg::rec_t rec_reg;
    sis_pkg::rec_t rec_next;

    // the new record takes this cell's place when the cell is empty or holds a strictly smaller key
    assign gt  = !occupied || (rec_reg.key < new_rec.key);
    assign rec = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        priority if (ctrl.shift)
        begin
            rec_next = right_rec;
        end
        else if (ctrl.ins && gt)
        begin
            rec_next = left_gt ? left_rec : new_rec;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

>>> rtl/core/stable_descending_insertion_sorter.sv
// top level of the stable descending insertion sorter
// Records stream in one word per cycle and are placed at once into a chain of
// sis_pkg::CAPACITY cells kept in descending key order; equal keys keep their
// arrival order. The word with tlast also enters the chain unless it is full,
// then input stalls while the stored set (at most sis_pkg::CAPACITY records)
// drains from cell 0, one word per cycle while m_tready is high, and input
// reopens right after the last word. Records that arrive with the chain full
// are dropped and tuser flags every word of that set.
module stable_descending_insertion_sorter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sis_pkg::DATA_BITS-1:0] s_tdata,  // score_key, record_tag
    input  logic                          s_tlast,  // final_record
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sis_pkg::DATA_BITS-1:0] m_tdata,  // sorted_key, sorted_tag
    output logic                          m_tlast,  // end_of_set
    output logic                          m_tuser   // overflowed
);

    localparam int N = sis_pkg::CAPACITY;

    sis_pkg::state_t               state_reg, state_next;
    logic [sis_pkg::FILL_BITS-1:0] fill_reg, fill_next;
    logic                          drop_reg, drop_next;

    sis_pkg::rec_t      in_rec;
    sis_pkg::rec_t      rec_q [N];
    logic [N-1:0]       gt_q;
    logic [N-1:0]       occupied;
    sis_pkg::cell_ctrl_t ctrl;

    logic in_acc;
    logic out_acc;
    logic full;
    logic last_out;

    assign in_rec.key = s_tdata[sis_pkg::KEY_BITS-1:0];
    assign in_rec.tag = s_tdata[sis_pkg::KEY_BITS +: sis_pkg::TAG_BITS];

    assign s_tready = (state_reg == sis_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == sis_pkg::ST_DRAIN);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign full     = (fill_reg == sis_pkg::FILL_BITS'(N));
    assign last_out = (fill_reg == sis_pkg::FILL_BITS'(1));

    assign ctrl.ins   = in_acc && !full;
    assign ctrl.shift = out_acc;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            sis_pkg::rec_t left_rec;
            sis_pkg::rec_t right_rec;
            logic          left_gt;

            assign occupied[i] = (sis_pkg::FILL_BITS'(i) < fill_reg);

            if (i == 0)
            begin : g_first
                assign left_rec = in_rec;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_mid
                assign left_rec = rec_q[i-1];
                assign left_gt  = gt_q[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign right_rec = rec_q[i];
            end
            else
            begin : g_inner
                assign right_rec = rec_q[i+1];
            end

            sis_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (occupied[i]),
                .new_rec   (in_rec),
                .left_rec  (left_rec),
                .left_gt   (left_gt),
                .right_rec (right_rec),
                .rec       (rec_q[i]),
                .gt        (gt_q[i])
            );
        end
    endgenerate

    generate
        if (sis_pkg::PAD_BITS > 0)
        begin : g_pad
            assign m_tdata = {{sis_pkg::PAD_BITS{1'b0}}, rec_q[0].tag, rec_q[0].key};
        end
        else
        begin : g_nopad
            assign m_tdata = {rec_q[0].tag, rec_q[0].key};
        end
    endgenerate

    assign m_tlast = last_out;
    assign m_tuser = drop_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            sis_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + sis_pkg::FILL_BITS'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = sis_pkg::ST_DRAIN;
                    end
                end
            end
            sis_pkg::ST_DRAIN:
            begin
                if (out_acc)
                begin
                    fill_next = fill_reg - sis_pkg::FILL_BITS'(1);
                    if (last_out)
                    begin
                        drop_next  = 1'b0;
                        state_next = sis_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = sis_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sis_pkg::ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    // chain never holds more records than cells
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= sis_pkg::FILL_BITS'(N))
        else $error("fill count beyond capacity");

    // draining always has a word to show
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sis_pkg::ST_DRAIN) |-> (fill_reg != '0))
        else $error("drain with empty chain");

    // the final word leaves the chain empty and reopens input
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_tlast) |=> (s_tready && fill_reg == '0 && !drop_reg))
        else $error("set not closed after last word");

    // a last input word starts the drain
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tlast) |=> (m_tvalid && !s_tready))
        else $error("drain did not start");

endmodule
